@@ rtl/dtpm_pkg.sv @@
`timescale 1ns / 1ps

package dtpm_pkg;

    // field widths
    localparam int SampleW = 10;
    localparam int HitsW   = 8;
    localparam int TimeW   = 32;

    // stream widths, padded to whole bytes
    localparam int SDataW = 16;
    localparam int MDataW = 32;

    // configuration port
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 10;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegThreshold    = 1'd0;
    localparam logic [CfgIdxW-1:0] RegDebounceHits = 1'd1;

    // reset values of the registers
    localparam logic [SampleW-1:0] ThresholdRst    = 10'd32;
    localparam logic [HitsW-1:0]   DebounceHitsRst = 8'd5;

    // item kinds carried on tuser
    localparam logic ActTick   = 1'b0;
    localparam logic ActSample = 1'b1;

    // one input beat
    typedef struct packed {
        logic               action;
        logic [SampleW-1:0] sample;
    } t_item;

    // configuration seen by the core
    typedef struct packed {
        logic [SampleW-1:0] threshold;
        logic [HitsW-1:0]   hits_needed;
    } t_cfg;

    // what the core reports for the item it holds
    typedef struct packed {
        logic             emit;
        logic [TimeW-1:0] period;
    } t_res;

endpackage

@@ rtl/debounced_threshold_period_meter_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: sample; tuser: action
// m_axis    out        m_axis_tvalid/tready      tdata: period_ticks
// cfg       in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One beat is taken every cycle unless the held beat waits for a full output; a beat
// is held in the input register and its result, if any, is then registered on output.
// Synchronous active-low reset clears the phase, hit counters, time and marks.
// A stalled output only holds back a sample that would produce a result;
// ticks and other samples keep flowing past a waiting result.

module debounced_threshold_period_meter_unit import dtpm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SDataW-1:0]   s_axis_tdata,   // [9:0] sample, [15:10] zero
    input  logic                s_axis_tuser,   // [0] action
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [MDataW-1:0]   m_axis_tdata,   // [31:0] period_ticks
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    logic [TimeW-1:0]   r_out_data;
    t_res               res;
    logic               out_free;
    logic               fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= ThresholdRst;
            r_cfg.hits_needed <= DebounceHitsRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegThreshold:    r_cfg.threshold   <= i_cfg_data[SampleW-1:0];
                RegDebounceHits: r_cfg.hits_needed <= i_cfg_data[HitsW-1:0];
                default: ;
            endcase
        end
    end

    // held item moves on unless it needs a full output slot
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && (!res.emit || out_free);
    assign s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.action <= s_axis_tuser;
            r_item.sample <= s_axis_tdata[SampleW-1:0];
        end
    end

    dtpm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.emit) begin
            r_out_data <= res.period;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a result-producing item always lands in the output register
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.emit |=> r_out_valid)
        else $error("result lost");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !(fire && res.emit))
        else $error("waiting result overwritten");

    // a blocked item stays in the input register
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_item))
        else $error("blocked item dropped");

    // not ready only while an item is held
    a_ready_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && res.emit && !out_free)
        else $error("input stalled without cause");

endmodule

@@ rtl/dtpm_core.sv @@
`timescale 1ns / 1ps

module dtpm_core import dtpm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,   // item in the input register is consumed this cycle
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    typedef enum logic [2:0] {
        PH_WAIT_FALL = 3'd0,
        PH_DEB_FALL  = 3'd1,
        PH_FALL_SEEN = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_DEB_RISE  = 3'd4,
        PH_RISE_SEEN = 3'd5
    } t_phase;

    t_phase             r_phase,     n_phase;
    logic [HitsW-1:0]   r_low_hits,  n_low_hits;
    logic [HitsW-1:0]   r_high_hits, n_high_hits;
    logic [TimeW-1:0]   r_time_now,  n_time_now;
    logic [TimeW-1:0]   r_rise_mark, n_rise_mark;
    logic [TimeW-1:0]   r_fall_mark, n_fall_mark;
    logic [TimeW-1:0]   r_high_time, n_high_time;
    logic               below;
    logic [HitsW-1:0]   low_inc;
    logic [HitsW-1:0]   high_inc;

    assign below    = i_item.sample < i_cfg.threshold;
    assign low_inc  = r_low_hits + 1'b1;
    assign high_inc = r_high_hits + 1'b1;

    // result goes out on the sample that follows an accepted rising edge
    assign o_res.emit   = (i_item.action == ActSample) && (r_phase == PH_RISE_SEEN);
    assign o_res.period = (r_time_now - r_fall_mark) + r_high_time;

    // next state for the held item
    always_comb begin
        n_phase     = r_phase;
        n_low_hits  = r_low_hits;
        n_high_hits = r_high_hits;
        n_time_now  = r_time_now;
        n_rise_mark = r_rise_mark;
        n_fall_mark = r_fall_mark;
        n_high_time = r_high_time;
        if (i_item.action == ActTick) begin
            n_time_now = r_time_now + 1'b1;
        end else begin
            case (r_phase)
                PH_DEB_FALL: begin
                    if (below) begin
                        n_low_hits = low_inc;
                        if (low_inc >= i_cfg.hits_needed) n_phase = PH_FALL_SEEN;
                    end else begin
                        n_low_hits = '0;
                    end
                end
                PH_FALL_SEEN: begin
                    n_fall_mark = r_time_now;
                    n_high_time = r_time_now - r_rise_mark;
                    n_phase     = PH_WAIT_RISE;
                end
                PH_WAIT_RISE: begin
                    if (!below) begin
                        n_phase     = PH_DEB_RISE;
                        n_low_hits  = '0;
                        n_high_hits = HitsW'(1);
                    end
                end
                PH_DEB_RISE: begin
                    if (!below) begin
                        n_high_hits = high_inc;
                        if (high_inc >= i_cfg.hits_needed) n_phase = PH_RISE_SEEN;
                    end else begin
                        n_high_hits = '0;
                    end
                end
                PH_RISE_SEEN: begin
                    n_rise_mark = r_time_now;
                    n_phase     = PH_WAIT_FALL;
                end
                default: begin
                    // waiting for the falling edge
                    if (below) begin
                        n_phase     = PH_DEB_FALL;
                        n_low_hits  = HitsW'(1);
                        n_high_hits = '0;
                    end else begin
                        n_phase = PH_WAIT_FALL;
                    end
                end
            endcase
        end
    end

    // state update, one item per cycle while i_fire is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT_FALL;
            r_low_hits  <= '0;
            r_high_hits <= '0;
            r_time_now  <= '0;
            r_rise_mark <= '0;
            r_fall_mark <= '0;
            r_high_time <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_low_hits  <= n_low_hits;
            r_high_hits <= n_high_hits;
            r_time_now  <= n_time_now;
            r_rise_mark <= n_rise_mark;
            r_fall_mark <= n_fall_mark;
            r_high_time <= n_high_time;
        end
    end

    // the sample after an accepted falling edge stamps it and starts the rising half
    a_fall_to_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ActSample && r_phase == PH_FALL_SEEN
        |=> r_phase == PH_WAIT_RISE && r_fall_mark == $past(r_time_now))
        else $error("fall timestamp not taken");

    // ticks move only the time counter
    a_tick_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ActTick
        |=> $stable(r_phase) && r_time_now == $past(r_time_now) + 1'b1)
        else $error("tick disturbed the phase");

    // a result is only reported for a sample beat
    a_emit_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit |-> i_item.action == ActSample)
        else $error("result on a tick");

endmodule

@@ verif/debounced_threshold_period_meter_unit_tb.sv @@
`timescale 1ns / 1ps

module debounced_threshold_period_meter_unit_tb;
    import dtpm_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int DrainLimit   = 20000;
    localparam int SettleCycles = 6;
    localparam int IdlePct      = 37;

    // phases of the edge detector
    typedef enum logic [2:0] {
        WaitFall, DebFall, FallSeen, WaitRise, DebRise, RiseSeen
    } t_phase;

    // one directed beat; fixed marks a row whose period is typed in
    typedef struct packed {
        logic               act;
        logic [SampleW-1:0] smp;
        logic               fixed;
        logic [TimeW-1:0]   val;
    } t_row;

    // reset config: threshold 32, five hits per edge
    localparam int DirLen = 22;
    localparam t_row DirRows [DirLen] = '{
        '{ActTick,   10'd0,    1'b0, 32'd0},
        '{ActTick,   10'd0,    1'b0, 32'd0},
        '{ActSample, 10'd0,    1'b0, 32'd0},  // first low, debounce starts
        '{ActSample, 10'd1023, 1'b0, 32'd0},  // miss clears the count
        '{ActSample, 10'd31,   1'b0, 32'd0},
        '{ActSample, 10'd5,    1'b0, 32'd0},
        '{ActSample, 10'd31,   1'b0, 32'd0},
        '{ActSample, 10'd0,    1'b0, 32'd0},
        '{ActSample, 10'd16,   1'b0, 32'd0},  // fifth hit, fall accepted
        '{ActSample, 10'd1023, 1'b0, 32'd0},  // swallowed, fall stamped at 2
        '{ActTick,   10'd0,    1'b0, 32'd0},
        '{ActTick,   10'd0,    1'b0, 32'd0},
        '{ActSample, 10'd32,   1'b0, 32'd0},  // equal to threshold counts high
        '{ActSample, 10'd0,    1'b0, 32'd0},  // miss
        '{ActSample, 10'd1023, 1'b0, 32'd0},
        '{ActSample, 10'd32,   1'b0, 32'd0},
        '{ActSample, 10'd700,  1'b0, 32'd0},
        '{ActSample, 10'd512,  1'b0, 32'd0},
        '{ActSample, 10'd1023, 1'b0, 32'd0},  // rise accepted
        '{ActTick,   10'd0,    1'b0, 32'd0},
        '{ActSample, 10'd0,    1'b1, 32'd5},  // swallowed, period from time zero
        '{ActSample, 10'd0,    1'b0, 32'd0}
    };

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                s_tvalid   = 1'b0;
    wire                 s_tready;
    logic [SDataW-1:0]   s_tdata    = '0;
    logic                s_tuser    = 1'b0;
    wire                 m_tvalid;
    logic                m_tready   = 1'b0;
    wire  [MDataW-1:0]   m_tdata;
    logic                cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx    = '0;
    logic [CfgDataW-1:0] cfg_data   = '0;

    // travels with the beat being offered
    logic                beat_fixed = 1'b0;
    logic [TimeW-1:0]    beat_val   = '0;

    bit                  calm       = 1'b0;
    int                  fail_count = 0;
    int                  cycle_cnt  = 0;

    // expected periods, oldest first
    logic [TimeW-1:0]    period_q [$];

    // shadow of the meter state and its registers
    logic [SampleW-1:0]  thr_q      = ThresholdRst;
    logic [HitsW-1:0]    hits_q     = DebounceHitsRst;
    t_phase              phase_q    = WaitFall;
    logic [HitsW-1:0]    low_cnt    = '0;
    logic [HitsW-1:0]    high_cnt   = '0;
    logic [TimeW-1:0]    time_cnt   = '0;
    logic [TimeW-1:0]    rise_at    = '0;
    logic [TimeW-1:0]    fall_at    = '0;
    logic [TimeW-1:0]    high_span  = '0;

    debounced_threshold_period_meter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // advance the shadow meter by one beat; returns 1 when a period comes out
    function automatic logic meter_step(input logic act, input logic [SampleW-1:0] smp,
                                        output logic [TimeW-1:0] period);
        logic below;
        period = '0;
        if (act == ActTick) begin
            time_cnt = time_cnt + 1'b1;
            return 1'b0;
        end
        below = (smp < thr_q);
        case (phase_q)
            DebFall: begin
                if (below) begin
                    low_cnt = low_cnt + 1'b1;
                    if (low_cnt >= hits_q) phase_q = FallSeen;
                end else begin
                    low_cnt = '0;
                end
            end
            FallSeen: begin
                fall_at   = time_cnt;
                high_span = fall_at - rise_at;
                phase_q   = WaitRise;
            end
            WaitRise: begin
                if (!below) begin
                    phase_q  = DebRise;
                    low_cnt  = '0;
                    high_cnt = 8'd1;
                end
            end
            DebRise: begin
                if (!below) begin
                    high_cnt = high_cnt + 1'b1;
                    if (high_cnt >= hits_q) phase_q = RiseSeen;
                end else begin
                    high_cnt = '0;
                end
            end
            RiseSeen: begin
                rise_at = time_cnt;
                period  = (rise_at - fall_at) + high_span;
                phase_q = WaitFall;
                return 1'b1;
            end
            default: begin
                if (below) begin
                    phase_q  = DebFall;
                    low_cnt  = 8'd1;
                    high_cnt = '0;
                end else begin
                    phase_q = WaitFall;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // watch both handshakes; values read here are those sampled at the edge
    always @(posedge i_clk) begin
        logic [TimeW-1:0] p;
        logic [TimeW-1:0] want;
        logic             got;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (period_q.size() == 0) begin
                    $error("period_ticks: expected none, actual %0d", m_tdata);
                    fail_count++;
                end else begin
                    want = period_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("period_ticks: expected %0d, actual %0d", want, m_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                got = meter_step(s_tuser, s_tdata[SampleW-1:0], p);
                if (got || beat_fixed) period_q.push_back(beat_fixed ? beat_val : p);
            end
        end
    end

    // random backpressure on the result side
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // offer one beat after a random gap and hold it until taken
    task automatic send_item(input logic act, input logic [SampleW-1:0] smp,
                             input logic fixed, input logic [TimeW-1:0] val);
        int gap;
        gap = 0;
        if (!calm) while ($urandom_range(0, 99) < IdlePct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= {{(SDataW-SampleW){1'b0}}, smp};
        beat_fixed <= fixed;
        beat_val   <= val;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // stop sending, let all periods arrive and the pipe drain;
    // one edge first so the last accepted beat is already predicted
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (period_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // both registers, back to back; the block is idle
    task automatic set_config(input logic [SampleW-1:0] thr, input logic [HitsW-1:0] hits);
        cfg_we   <= 1'b1;
        cfg_idx  <= RegThreshold;
        cfg_data <= thr;
        @(posedge i_clk);
        thr_q    = thr;
        cfg_idx  <= RegDebounceHits;
        cfg_data <= {{(CfgDataW-HitsW){1'b0}}, hits};
        @(posedge i_clk);
        hits_q   = hits;
        cfg_we   <= 1'b0;
    endtask

    // slow square wave around the threshold with ticks mixed in;
    // glitches and stray samples break some of the edges
    task automatic run_wave(input int n_items, input int pause_at);
        int                 dwell;
        bit                 lvl_low;
        bit                 want_low;
        bit                 noisy;
        logic               act;
        logic [SampleW-1:0] smp;
        noisy   = (hits_q < 32);
        dwell   = 0;
        lvl_low = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            if (k == pause_at) wait_idle();
            act = ($urandom_range(0, 99) < 30) ? ActTick : ActSample;
            smp = SampleW'($urandom_range(0, 1023));
            if (act == ActSample && $urandom_range(0, 99) >= 5) begin
                if (dwell == 0) begin
                    lvl_low = !lvl_low;
                    dwell   = hits_q + $urandom_range(1, 6);
                end
                dwell--;
                want_low = lvl_low ^ (noisy && ($urandom_range(0, 99) < 8));
                if (want_low && thr_q != 0) begin
                    smp = SampleW'($urandom_range(0, thr_q - 1));
                end else if (!want_low) begin
                    smp = SampleW'($urandom_range(thr_q, 1023));
                end
            end
            send_item(act, smp, 1'b0, '0);
        end
    endtask

    initial begin
        int drain;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset settings
        for (int r = 0; r < DirLen; r++) begin
            send_item(DirRows[r].act, DirRows[r].smp, DirRows[r].fixed, DirRows[r].val);
        end

        wait_idle();
        set_config(10'd512, 8'd3);
        run_wave(200, -1);

        // no idling on either side here
        wait_idle();
        calm = 1'b1;
        set_config(10'd1023, 8'd1);
        run_wave(200, -1);

        // nothing can be low: no periods at all
        wait_idle();
        calm = 1'b0;
        set_config(10'd0, 8'd255);
        run_wave(60, -1);

        // zero hits accepts on the first debouncing hit
        wait_idle();
        set_config(10'd1, 8'd0);
        run_wave(150, -1);

        // sender holds off mid-run until every period is out
        wait_idle();
        set_config(SampleW'($urandom_range(100, 900)), HitsW'($urandom_range(2, 10)));
        run_wave(250, 120);

        wait_idle();
        set_config(10'd800, 8'd255);
        run_wave(1100, -1);

        wait_idle();
        set_config(SampleW'($urandom_range(100, 900)), HitsW'($urandom_range(1, 6)));
        run_wave(100, -1);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        for (drain = 0; period_q.size() != 0 && drain < DrainLimit; drain++) begin
            @(posedge i_clk);
        end
        if (period_q.size() != 0) begin
            $error("period_ticks: %0d expected results never arrived", period_q.size());
            fail_count++;
        end
        repeat (SettleCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
